@@ sv/krt_pkg.sv @@
package krt_pkg;

	localparam int unsigned KEY_W         = 32;
	localparam int unsigned QTY_W         = 32;
	localparam int unsigned PRICE_W       = 32;
	localparam int unsigned ENTRY_COUNT_W = 8;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_PFX,
		S_ACT
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [QTY_W-1:0]   quantity;
		logic [PRICE_W-1:0] price_bits;
	} rec_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic write_qty;
	} cell_ctl_t;

endpackage

@@ sv/krt_if.sv @@
interface krt_cmd_if import krt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                cmd;
	logic signed [KEY_W-1:0]   key;
	logic signed [QTY_W-1:0]   quantity;
	logic [PRICE_W-1:0]        price_bits;

	modport source (output valid, cmd, key, quantity, price_bits, input ready);
	modport sink   (input valid, cmd, key, quantity, price_bits, output ready);
endinterface

interface krt_rsp_if import krt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic signed [QTY_W-1:0]   found_quantity;
	logic [PRICE_W-1:0]        found_price_bits;
	logic [ENTRY_COUNT_W-1:0]  entry_count;

	modport source (output valid, status, found_quantity, found_price_bits, entry_count,
		input ready);
	modport sink   (input valid, status, found_quantity, found_price_bits, entry_count,
		output ready);
endinterface

@@ sv/keyed_record_table_with_compaction.sv @@
// Keyed record table: an ordered list of up to CAPACITY records (key, quantity,
// price word) kept in a row of cells, lowest index first.
// req channel carries one command beat: append, lookup, update quantity or
// delete first match. rsp channel returns one beat per command with status,
// the quantity and price of the matched entry (before any change) and the
// entry count after the command.
// The command passes through the key compare register across all cells, the
// first-match prefix register, and the action step in which the cells load,
// shift or update and the response is written; a new command is taken only
// after the previous one has finished that step.
// Delete compacts the table in that action step: every cell above the match
// takes its upper neighbor's record.
// Reset empties the table (all cells invalid, count zero); record contents are
// not cleared. A stalled response holds the block before the table is changed,
// and req.ready stays low until the block has returned to idle.
module keyed_record_table_with_compaction import krt_pkg::*; #(
	parameter int unsigned CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	krt_cmd_if.sink     req,
	krt_rsp_if.source   rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	cmd_t             cmd_q;
	rec_t             req_rec_q;
	logic [CNT_W-1:0] count_q;

	logic [CAPACITY-1:0] cell_match;
	logic [CAPACITY-1:0] cell_valid;
	rec_t                cell_rec [CAPACITY];
	cell_ctl_t           cell_ctl [CAPACITY];

	logic [CAPACITY-1:0] match_s1;
	logic [CAPACITY-1:0] pfx_s2;
	logic [CAPACITY-1:0] pfx_d;
	logic [CAPACITY-1:0] first_hit;
	rec_t                hit_rec;
	logic                found;
	logic                full;

	logic             req_ready;
	logic             act_fire;
	logic [CNT_W-1:0] count_d;
	status_t          status_d;
	rec_t             result_d;

	logic                     rsp_valid_q;
	status_t                  rsp_status_q;
	logic [QTY_W-1:0]         rsp_qty_q;
	logic [PRICE_W-1:0]       rsp_price_q;
	logic [ENTRY_COUNT_W-1:0] rsp_count_q;

	// ---------------- cell row ----------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rec_t nxt_rec;
		logic nxt_valid;
		logic below_valid;

		if (i == CAPACITY - 1) begin : g_top
			assign nxt_rec   = cell_rec[i];
			assign nxt_valid = 1'b0;
		end else begin : g_mid
			assign nxt_rec   = cell_rec[i+1];
			assign nxt_valid = cell_valid[i+1];
		end

		if (i == 0) begin : g_first
			assign below_valid = 1'b1;
		end else begin : g_rest
			assign below_valid = cell_valid[i-1];
		end

		always_comb begin
			cell_ctl[i].load      = act_fire && (cmd_q == CMD_APPEND)
				&& !cell_valid[i] && below_valid;
			cell_ctl[i].shift     = act_fire && (cmd_q == CMD_DELETE) && pfx_s2[i];
			cell_ctl[i].write_qty = act_fire && (cmd_q == CMD_UPDATE) && first_hit[i];
		end

		krt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl[i]),
			.new_rec    (req_rec_q),
			.nxt_rec    (nxt_rec),
			.nxt_valid  (nxt_valid),
			.search_key (req_rec_q.key),
			.rec        (cell_rec[i]),
			.valid      (cell_valid[i]),
			.match      (cell_match[i])
		);
	end

	// ---------------- first-match search ----------------
	// log-depth prefix OR: bit i set when any cell at or below i matched
	always_comb begin
		pfx_d = match_s1;
		for (int unsigned s = 1; s < CAPACITY; s = s * 2) begin
			pfx_d = pfx_d | (pfx_d << s);
		end
	end

	assign first_hit = pfx_s2 & ~(pfx_s2 << 1);
	assign found     = pfx_s2[CAPACITY-1];
	assign full      = cell_valid[CAPACITY-1];

	always_comb begin
		hit_rec = '0;
		for (int unsigned i = 0; i < CAPACITY; i++) begin
			hit_rec = hit_rec | (first_hit[i] ? cell_rec[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			match_s1 <= cell_match;
		end
		if (state_q == S_PFX) begin
			pfx_s2 <= pfx_d;
		end
	end

	// ---------------- control ----------------
	assign req_ready = (state_q == S_IDLE);
	assign act_fire  = (state_q == S_ACT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req.valid) state_d = S_CMP;
			S_CMP:  state_d = S_PFX;
			S_PFX:  state_d = S_ACT;
			S_ACT:  if (act_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		status_d = ST_OK;
		result_d = '0;
		count_d  = count_q;
		unique case (cmd_q)
			CMD_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_LOOKUP, CMD_UPDATE: begin
				if (found) begin
					result_d = hit_rec;
				end else begin
					status_d = ST_MISS;
				end
			end
			CMD_DELETE: begin
				if (found) begin
					result_d = hit_rec;
					count_d  = count_q - CNT_W'(1);
				end else begin
					status_d = ST_MISS;
				end
			end
			default: status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (act_fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			cmd_q                <= cmd_t'(req.cmd);
			req_rec_q.key        <= req.key;
			req_rec_q.quantity   <= req.quantity;
			req_rec_q.price_bits <= req.price_bits;
		end
		if (act_fire) begin
			rsp_status_q <= status_d;
			rsp_qty_q    <= result_d.quantity;
			rsp_price_q  <= result_d.price_bits;
			rsp_count_q  <= ENTRY_COUNT_W'(count_d);
		end
	end

	assign req.ready            = req_ready;
	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.found_quantity   = rsp_qty_q;
	assign rsp.found_price_bits = rsp_price_q;
	assign rsp.entry_count      = rsp_count_q;

endmodule

@@ sv/krt_cell.sv @@
module krt_cell import krt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  rec_t             new_rec,
	input  rec_t             nxt_rec,
	input  logic             nxt_valid,
	input  logic [KEY_W-1:0] search_key,
	output rec_t             rec,
	output logic             valid,
	output logic             match
);

	rec_t rec_q;
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (ctl.shift) begin
			valid_q <= nxt_valid;
		end
	end

	// take a new record, pull the upper neighbor down, or overwrite quantity
	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			rec_q <= new_rec;
		end else if (ctl.shift) begin
			rec_q <= nxt_rec;
		end else if (ctl.write_qty) begin
			rec_q.quantity <= new_rec.quantity;
		end
	end

	assign rec   = rec_q;
	assign valid = valid_q;
	assign match = valid_q && (rec_q.key == search_key);

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import krt_pkg::*;

	localparam int unsigned TABLE_DEPTH = 128;
	localparam int unsigned KEY_POOL_N  = 24;
	localparam int unsigned PHASE_LEN   = 150;
	localparam int unsigned PHASE_CNT   = 13;

	typedef enum int unsigned {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	typedef struct {
		status_t                 status;
		logic signed [QTY_W-1:0] quantity;
		logic [PRICE_W-1:0]      price_bits;
		logic [ENTRY_COUNT_W-1:0] count;
	} table_rsp_t;

	typedef struct {
		cmd_t                    op;
		logic [KEY_W-1:0]        key;
		logic [QTY_W-1:0]        quantity;
		logic [PRICE_W-1:0]      price_bits;
		bit                      typed;
		table_rsp_t              want;
	} table_step_t;

	logic clk;
	logic arst_n;

	krt_cmd_if cmd_bus ();
	krt_rsp_if rsp_bus ();

	keyed_record_table_with_compaction #(
		.CAPACITY(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (cmd_bus),
		.rsp   (rsp_bus)
	);

	// Mirror of the table contents, lowest index first
	logic [KEY_W-1:0]   tbl_key[$];
	logic [QTY_W-1:0]   tbl_qty[$];
	logic [PRICE_W-1:0] tbl_price[$];

	table_rsp_t       pending_rsp[$];
	logic [KEY_W-1:0] key_pool[KEY_POOL_N];
	table_step_t      directed[];

	int unsigned mismatch_count;
	int unsigned rsp_seen;
	int unsigned burst_left;
	int unsigned op_count[4];
	int unsigned full_refusals;
	int unsigned miss_count;
	int unsigned peak_entries;

	function automatic table_rsp_t table_apply(cmd_t op, logic [KEY_W-1:0] k,
			logic [QTY_W-1:0] q, logic [PRICE_W-1:0] p);
		table_rsp_t r;
		int hit;
		r.status     = ST_OK;
		r.quantity   = '0;
		r.price_bits = '0;
		hit          = -1;
		if (op == CMD_APPEND) begin
			if (tbl_key.size() >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				tbl_key.push_back(k);
				tbl_qty.push_back(q);
				tbl_price.push_back(p);
			end
		end else begin
			foreach (tbl_key[i])
				if (hit < 0 && tbl_key[i] == k) hit = i;
			if (hit < 0) begin
				r.status = ST_MISS;
			end else begin
				r.quantity   = tbl_qty[hit];
				r.price_bits = tbl_price[hit];
				if (op == CMD_UPDATE) begin
					tbl_qty[hit] = q;
				end else if (op == CMD_DELETE) begin
					// later entries slide down one place
					tbl_key.delete(hit);
					tbl_qty.delete(hit);
					tbl_price.delete(hit);
				end
			end
		end
		r.count = ENTRY_COUNT_W'(tbl_key.size());
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40 && tbl_key.size() > 0)
			return tbl_key[$urandom_range(0, tbl_key.size() - 1)];
		if (roll < 85)
			return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
		return $urandom();
	endfunction

	function automatic cmd_t pick_op(phase_t ph);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				if (roll < 80) return CMD_APPEND;
				if (roll < 88) return CMD_LOOKUP;
				if (roll < 95) return CMD_UPDATE;
				return CMD_DELETE;
			end
			PH_DRAIN: begin
				if (roll < 10) return CMD_APPEND;
				if (roll < 25) return CMD_LOOKUP;
				if (roll < 40) return CMD_UPDATE;
				return CMD_DELETE;
			end
			default: begin
				if (roll < 30) return CMD_APPEND;
				if (roll < 55) return CMD_LOOKUP;
				if (roll < 75) return CMD_UPDATE;
				return CMD_DELETE;
			end
		endcase
	endfunction

	// Drive one command beat, hold until accepted, then queue its response
	task automatic issue_command(table_step_t s);
		table_rsp_t predicted;
		cmd_bus.valid      <= 1'b1;
		cmd_bus.cmd        <= s.op;
		cmd_bus.key        <= s.key;
		cmd_bus.quantity   <= s.quantity;
		cmd_bus.price_bits <= s.price_bits;
		@(posedge clk);
		while (cmd_bus.ready !== 1'b1) @(posedge clk);
		predicted = table_apply(s.op, s.key, s.quantity, s.price_bits);
		pending_rsp.push_back(s.typed ? s.want : predicted);
		op_count[s.op]++;
		if (predicted.status == ST_FULL) full_refusals++;
		if (predicted.status == ST_MISS) miss_count++;
		if (predicted.count > peak_entries) peak_entries = predicted.count;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : stimulus
		table_step_t s;
		phase_t ph;
		arst_n             <= 1'b0;
		cmd_bus.valid      <= 1'b0;
		cmd_bus.cmd        <= CMD_APPEND;
		cmd_bus.key        <= '0;
		cmd_bus.quantity   <= '0;
		cmd_bus.price_bits <= '0;
		mismatch_count = 0;
		burst_left     = 0;
		full_refusals  = 0;
		miss_count     = 0;
		peak_entries   = 0;
		foreach (op_count[i]) op_count[i] = 0;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'h8000_0000;
		key_pool[2] = 32'h7fff_ffff;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < KEY_POOL_N; i++) key_pool[i] = $urandom();

		directed = '{
			'{CMD_LOOKUP, 32'h0, 32'h1, 32'h1, 1'b1,
				'{ST_MISS, 32'h0, 32'h0, 8'd0}},
			'{CMD_UPDATE, 32'h0, 32'h5, 32'h0, 1'b1,
				'{ST_MISS, 32'h0, 32'h0, 8'd0}},
			'{CMD_DELETE, 32'hffff_ffff, 32'h0, 32'h0, 1'b1,
				'{ST_MISS, 32'h0, 32'h0, 8'd0}},
			'{CMD_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1,
				'{ST_OK, 32'h0, 32'h0, 8'd1}},
			'{CMD_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 1'b1,
				'{ST_OK, 32'h0, 32'h0, 8'd2}},
			'{CMD_APPEND, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 1'b1,
				'{ST_OK, 32'h0, 32'h0, 8'd3}},
			// second record under an existing key
			'{CMD_APPEND, 32'h7fff_ffff, 32'h0000_0005, 32'ha5a5_a5a5, 1'b1,
				'{ST_OK, 32'h0, 32'h0, 8'd4}},
			'{CMD_LOOKUP, 32'h7fff_ffff, 32'h1234_5678, 32'h0, 1'b1,
				'{ST_OK, 32'h8000_0000, 32'h0, 8'd4}},
			'{CMD_UPDATE, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 1'b1,
				'{ST_OK, 32'h8000_0000, 32'h0, 8'd4}},
			'{CMD_LOOKUP, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1,
				'{ST_OK, 32'h0, 32'h0, 8'd4}},
			'{CMD_APPEND, 32'h5a5a_5a5a, 32'h3c3c_3c3c, 32'hc3c3_c3c3, 1'b0,
				'{ST_OK, 32'h0, 32'h0, 8'd0}},
			'{CMD_DELETE, 32'h8000_0000, 32'h0, 32'h0, 1'b1,
				'{ST_OK, 32'h7fff_ffff, 32'hffff_ffff, 8'd4}},
			'{CMD_LOOKUP, 32'h8000_0000, 32'h0, 32'h0, 1'b1,
				'{ST_MISS, 32'h0, 32'h0, 8'd4}},
			'{CMD_DELETE, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1,
				'{ST_OK, 32'h0, 32'h0, 8'd3}},
			'{CMD_LOOKUP, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1,
				'{ST_OK, 32'h5, 32'ha5a5_a5a5, 8'd3}},
			'{CMD_UPDATE, 32'h5a5a_5a5a, 32'h8000_0000, 32'h0, 1'b0,
				'{ST_OK, 32'h0, 32'h0, 8'd0}},
			'{CMD_DELETE, 32'h0000_0000, 32'h0, 32'h0, 1'b1,
				'{ST_OK, 32'hffff_ffff, 32'h1, 8'd2}},
			'{CMD_DELETE, 32'h5a5a_5a5a, 32'h0, 32'h0, 1'b0,
				'{ST_OK, 32'h0, 32'h0, 8'd0}},
			'{CMD_DELETE, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1,
				'{ST_OK, 32'h5, 32'ha5a5_a5a5, 8'd0}}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) issue_command(directed[i]);

		// Run a fill phase, then a drain phase, then phases of random kind
		s.typed = 1'b0;
		s.want  = '{ST_OK, 32'h0, 32'h0, 8'd0};
		for (int unsigned n = 0; n < PHASE_CNT; n++) begin
			if (n == 0) ph = PH_FILL;
			else if (n == 1) ph = PH_DRAIN;
			else ph = phase_t'($urandom_range(0, 2));
			for (int unsigned j = 0; j < PHASE_LEN; j++) begin
				s.op         = pick_op(ph);
				s.key        = pick_key();
				s.quantity   = $urandom();
				s.price_bits = $urandom();
				issue_command(s);
			end
		end
		cmd_bus.valid <= 1'b0;

		while (pending_rsp.size() > 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("Covered %0d appends (%0d refused on a full table), %0d lookups, %0d updates,",
			op_count[CMD_APPEND], full_refusals, op_count[CMD_LOOKUP], op_count[CMD_UPDATE]);
		$display("%0d deletes, %0d key misses, peak of %0d entries; %0d responses checked.",
			op_count[CMD_DELETE], miss_count, peak_entries, rsp_seen);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : rsp_sink
		logic [15:0] stall_pat;
		int unsigned tick;
		table_rsp_t want;
		rsp_bus.ready <= 1'b0;
		stall_pat = 16'hffff;
		tick      = 0;
		rsp_seen  = 0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
				rsp_seen++;
				if (pending_rsp.size() == 0) begin
					mismatch_count++;
					$display("%0t: response beat with nothing expected: status %0d qty %0d",
						$time, rsp_bus.status, rsp_bus.found_quantity);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp_bus.status !== want.status
							|| rsp_bus.found_quantity !== want.quantity
							|| rsp_bus.found_price_bits !== want.price_bits
							|| rsp_bus.entry_count !== want.count) begin
						mismatch_count++;
						$display("%0t: expected status %0d qty %0d price %h count %0d",
							$time, want.status, want.quantity, want.price_bits, want.count);
						$display("%0t:   actual status %0d qty %0d price %h count %0d",
							$time, rsp_bus.status, rsp_bus.found_quantity,
							rsp_bus.found_price_bits, rsp_bus.entry_count);
					end
				end
			end
			// switch stall pattern now and then; keep at least one ready slot
			if (tick % 200 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pat = 16'hffff;
					1: stall_pat = 16'h0101;
					default: stall_pat = 16'($urandom()) | 16'h0001;
				endcase
			end
			rsp_bus.ready <= stall_pat[tick % 16];
			tick++;
		end
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ keyed_record_table_with_compaction.f @@
sv/krt_pkg.sv
sv/krt_if.sv
sv/krt_cell.sv
sv/keyed_record_table_with_compaction.sv
sim/testbench.sv
